// ===== rtl/sct_pkg.sv =====
// Shared types, character codes and token kinds for the shell command tokenizer.
// Depends on nothing; every other file of the block uses it.
package sct_pkg;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_LT      = 8'h3C;
    localparam logic [7:0] CHAR_GT      = 8'h3E;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_BAR     = 8'h7C;

    localparam logic [3:0] KIND_COMMENT = 4'd0;
    localparam logic [3:0] KIND_RIN     = 4'd1;
    localparam logic [3:0] KIND_ROUT    = 4'd2;
    localparam logic [3:0] KIND_AND     = 4'd3;
    localparam logic [3:0] KIND_PIPE    = 4'd4;
    localparam logic [3:0] KIND_OR      = 4'd5;
    localparam logic [3:0] KIND_NEWLINE = 4'd6;
    localparam logic [3:0] KIND_STRING  = 4'd7;
    localparam logic [3:0] KIND_UNKNOWN = 4'd8;
    localparam logic [3:0] KIND_END     = 4'd9;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic is_word_char(input logic [7:0] b);
        return (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ||
               (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
               b == CHAR_UNDER || b == CHAR_DOT || b == CHAR_SLASH;
    endfunction

endpackage

// ===== rtl/shell_command_tokenizer.sv =====
// Shell command tokenizer top level: input byte register, lexer core and a two-entry token queue.
// Depends on sct_pkg and sct_lexer.
// A token passes the input byte register and then the token queue before it is presented.
// Throughput: one byte per cycle while the queue has room; a two-token byte needs both slots free.
// Reset clears scan state, position, line count and the queue; no clearing pass is needed.
module shell_command_tokenizer #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_in,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      in_byte_reg, in_byte_next;
    sct_pkg::token_t q0_reg, q0_next;
    sct_pkg::token_t q1_reg, q1_next;
    logic [1:0]      cnt_reg, cnt_next;

    sct_pkg::token_t result0;
    sct_pkg::token_t result1;
    logic [1:0]      result_count;
    logic            pop;
    logic [1:0]      base;
    logic [2:0]      fill;
    logic            fire;

    sct_lexer #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_in      (in_byte_reg),
        .advance      (fire),
        .result0      (result0),
        .result1      (result1),
        .result_count (result_count)
    );

    assign token_valid  = (cnt_reg != 2'd0);
    assign token_kind   = q0_reg.kind;
    assign token_start  = q0_reg.start;
    assign token_length = q0_reg.length;
    assign line_number  = q0_reg.line;
    assign last_of_run  = q0_reg.last;

    assign pop        = token_valid && token_ready;
    assign base       = cnt_reg - {1'b0, pop};
    assign fill       = {1'b0, base} + {1'b0, result_count};
    assign fire       = in_valid_reg && (fill <= 3'd2);
    assign byte_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (byte_ready)
        begin
            in_valid_next = byte_valid;
            in_byte_next  = byte_in;
        end

        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = base;
        if (pop)
        begin
            q0_next = q1_reg;
        end
        if (fire)
        begin
            cnt_next = fill[1:0];
            if (base == 2'd0)
            begin
                q0_next = result0;
                q1_next = result1;
            end
            else if (base == 2'd1)
            begin
                q1_next = result0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        q0_reg      <= q0_next;
        q1_reg      <= q1_next;
    end

    // The queue never holds more than two tokens.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("token queue count out of range");

    // A byte with two tokens only advances when both fit after the pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result_count == 2'd2) |-> (base == 2'd0))
        else $error("double token written into occupied queue");

    // An empty input register always takes a new request.
    assert property (@(posedge clk) disable iff (!rst_n) !in_valid_reg |-> byte_ready)
        else $error("input register empty but not ready");

    // A two-token byte written with no pop leaves two tokens, the front one not the last of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result_count == 2'd2 && !pop) |=> (cnt_reg == 2'd2 && !q0_reg.last))
        else $error("first of two tokens marked as last");

endmodule

// ===== rtl/sct_lexer.sv =====
// Lexer core: scan state and counters, and the up to two tokens that one byte causes.
// Depends on sct_pkg.
module sct_lexer #(
    parameter int COUNTER_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        byte_in,
    input  logic              advance,
    output sct_pkg::token_t   result0,
    output sct_pkg::token_t   result1,
    output logic [1:0]        result_count
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AMP,
        MODE_BAR,
        MODE_STR
    } mode_t;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
    localparam logic [COUNTER_BITS-1:0] CNT_TWO = COUNTER_BITS'(2);

    mode_t                   mode_reg, mode_next;
    logic [COUNTER_BITS-1:0] pos_reg, pos_next;
    logic [COUNTER_BITS-1:0] pend_start_reg, pend_start_next;
    logic [COUNTER_BITS-1:0] pend_len_reg, pend_len_next;
    logic [COUNTER_BITS-1:0] line_reg, line_next;

    logic [COUNTER_BITS-1:0] pos_inc;
    logic [COUNTER_BITS-1:0] line_inc;
    logic                    has_flush;
    logic                    has_fresh;
    logic                    done;
    sct_pkg::token_t         flush_tok;
    sct_pkg::token_t         fresh_tok;

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [15:0] low16(input logic [COUNTER_BITS-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[15:0];
    endfunction

    assign pos_inc  = sat_inc(pos_reg);
    assign line_inc = sat_inc(line_reg);

    always_comb
    begin
        has_flush       = 1'b0;
        has_fresh       = 1'b0;
        done            = 1'b0;
        flush_tok       = '0;
        fresh_tok       = '0;
        mode_next       = mode_reg;
        pos_next        = pos_inc;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        line_next       = line_reg;

        flush_tok.start = low16(pend_start_reg);
        flush_tok.line  = low16(line_reg);
        case (mode_reg)
            MODE_AMP:
            begin
                has_flush = 1'b1;
                mode_next = MODE_IDLE;
                if (byte_in == sct_pkg::CHAR_AMP)
                begin
                    done             = 1'b1;
                    flush_tok.kind   = sct_pkg::KIND_AND;
                    flush_tok.length = low16(CNT_TWO);
                end
                else
                begin
                    flush_tok.kind   = sct_pkg::KIND_UNKNOWN;
                    flush_tok.length = low16(CNT_ONE);
                end
            end
            MODE_BAR:
            begin
                has_flush = 1'b1;
                mode_next = MODE_IDLE;
                if (byte_in == sct_pkg::CHAR_BAR)
                begin
                    done             = 1'b1;
                    flush_tok.kind   = sct_pkg::KIND_OR;
                    flush_tok.length = low16(CNT_TWO);
                end
                else
                begin
                    flush_tok.kind   = sct_pkg::KIND_PIPE;
                    flush_tok.length = low16(CNT_ONE);
                end
            end
            MODE_STR:
            begin
                if (sct_pkg::is_word_char(byte_in))
                begin
                    done          = 1'b1;
                    pend_len_next = sat_inc(pend_len_reg);
                end
                else
                begin
                    has_flush        = 1'b1;
                    mode_next        = MODE_IDLE;
                    flush_tok.kind   = sct_pkg::KIND_STRING;
                    flush_tok.length = low16(pend_len_reg);
                end
            end
            default:
            begin
            end
        endcase

        fresh_tok.start  = low16(pos_reg);
        fresh_tok.length = low16(CNT_ONE);
        fresh_tok.line   = low16(line_reg);
        if (!done)
        begin
            case (byte_in)
                sct_pkg::CHAR_SPACE, sct_pkg::CHAR_TAB:
                begin
                    mode_next = MODE_IDLE;
                end
                sct_pkg::CHAR_NUL:
                begin
                    has_fresh        = 1'b1;
                    mode_next        = MODE_IDLE;
                    fresh_tok.kind   = sct_pkg::KIND_END;
                    fresh_tok.length = '0;
                    pos_next         = '0;
                end
                sct_pkg::CHAR_HASH:
                begin
                    has_fresh      = 1'b1;
                    mode_next      = MODE_IDLE;
                    fresh_tok.kind = sct_pkg::KIND_COMMENT;
                end
                sct_pkg::CHAR_LT:
                begin
                    has_fresh      = 1'b1;
                    mode_next      = MODE_IDLE;
                    fresh_tok.kind = sct_pkg::KIND_RIN;
                end
                sct_pkg::CHAR_GT:
                begin
                    has_fresh      = 1'b1;
                    mode_next      = MODE_IDLE;
                    fresh_tok.kind = sct_pkg::KIND_ROUT;
                end
                sct_pkg::CHAR_NL:
                begin
                    has_fresh      = 1'b1;
                    mode_next      = MODE_IDLE;
                    fresh_tok.kind = sct_pkg::KIND_NEWLINE;
                    fresh_tok.line = low16(line_inc);
                    line_next      = line_inc;
                end
                sct_pkg::CHAR_AMP:
                begin
                    mode_next       = MODE_AMP;
                    pend_start_next = pos_reg;
                    pend_len_next   = CNT_ONE;
                end
                sct_pkg::CHAR_BAR:
                begin
                    mode_next       = MODE_BAR;
                    pend_start_next = pos_reg;
                    pend_len_next   = CNT_ONE;
                end
                default:
                begin
                    mode_next       = MODE_STR;
                    pend_start_next = pos_reg;
                    pend_len_next   = CNT_ONE;
                end
            endcase
        end

        flush_tok.last = !has_fresh;
        fresh_tok.last = 1'b1;
    end

    always_comb
    begin
        result1      = fresh_tok;
        result_count = {1'b0, has_flush} + {1'b0, has_fresh};
        if (has_flush)
        begin
            result0 = flush_tok;
        end
        else
        begin
            result0 = fresh_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            pos_reg        <= '0;
            pend_start_reg <= '0;
            pend_len_reg   <= '0;
            line_reg       <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            pend_start_reg <= pend_start_next;
            pend_len_reg   <= pend_len_next;
            line_reg       <= line_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for shell_command_tokenizer: byte requests in, token results out.
// Holds its own lexer prediction and compares every token field by field.
// Depends on sct_pkg and the RTL of the tokenizer.
`timescale 1ns / 100ps

module tb_top;

    localparam int  CYCLE_LIMIT = 2_000_000;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_AMP, SCAN_BAR, SCAN_WORD} scan_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  byte_in = 8'h00;
    logic        token_valid;
    logic        token_ready = 1'b0;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    sct_pkg::token_t tokens_due[$];
    scan_e       lex_mode = SCAN_IDLE;
    logic [15:0] lex_pos = '0;
    logic [15:0] lex_tok_start = '0;
    logic [15:0] lex_tok_len = '0;
    logic [15:0] lex_lines = '0;

    int          mismatches = 0;
    int          cycle_count = 0;
    int          hold_off_cycles = 0;
    bit          idling_on = 1'b1;

    shell_command_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_in     (byte_in),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_kind  (token_kind),
        .token_start (token_start),
        .token_length(token_length),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] sat_bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_name_byte(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               b == sct_pkg::CHAR_UNDER || b == sct_pkg::CHAR_DOT ||
               b == sct_pkg::CHAR_SLASH;
    endfunction

    function automatic sct_pkg::token_t make_token(input logic [3:0] kind,
                                                   input logic [15:0] start,
                                                   input logic [15:0] len);
        sct_pkg::token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.line   = lex_lines;
        t.last   = 1'b0;
        return t;
    endfunction

    // Advances the lexer prediction by one accepted byte and queues the tokens it causes.
    task automatic lex_byte(input logic [7:0] b);
        sct_pkg::token_t made[2];
        int          n;
        bit          consumed;
        logic [15:0] here;
        n = 0;
        consumed = 1'b0;
        here = lex_pos;
        case (lex_mode)
            SCAN_AMP:
            begin
                lex_mode = SCAN_IDLE;
                if (b == sct_pkg::CHAR_AMP)
                begin
                    made[n++] = make_token(sct_pkg::KIND_AND, lex_tok_start, 16'd2);
                    lex_pos = sat_bump(here);
                    consumed = 1'b1;
                end
                else
                    made[n++] = make_token(sct_pkg::KIND_UNKNOWN, lex_tok_start, 16'd1);
            end
            SCAN_BAR:
            begin
                lex_mode = SCAN_IDLE;
                if (b == sct_pkg::CHAR_BAR)
                begin
                    made[n++] = make_token(sct_pkg::KIND_OR, lex_tok_start, 16'd2);
                    lex_pos = sat_bump(here);
                    consumed = 1'b1;
                end
                else
                    made[n++] = make_token(sct_pkg::KIND_PIPE, lex_tok_start, 16'd1);
            end
            SCAN_WORD:
            begin
                if (is_name_byte(b))
                begin
                    lex_tok_len = sat_bump(lex_tok_len);
                    lex_pos = sat_bump(here);
                    consumed = 1'b1;
                end
                else
                begin
                    lex_mode = SCAN_IDLE;
                    made[n++] = make_token(sct_pkg::KIND_STRING, lex_tok_start, lex_tok_len);
                end
            end
            default: ;
        endcase
        if (!consumed)
        begin
            lex_pos = sat_bump(here);
            case (b)
                sct_pkg::CHAR_SPACE, sct_pkg::CHAR_TAB: ;
                sct_pkg::CHAR_NUL:
                begin
                    made[n++] = make_token(sct_pkg::KIND_END, here, 16'd0);
                    lex_pos = '0;
                end
                sct_pkg::CHAR_HASH: made[n++] = make_token(sct_pkg::KIND_COMMENT, here, 16'd1);
                sct_pkg::CHAR_LT:   made[n++] = make_token(sct_pkg::KIND_RIN, here, 16'd1);
                sct_pkg::CHAR_GT:   made[n++] = make_token(sct_pkg::KIND_ROUT, here, 16'd1);
                sct_pkg::CHAR_NL:
                begin
                    lex_lines = sat_bump(lex_lines);
                    made[n++] = make_token(sct_pkg::KIND_NEWLINE, here, 16'd1);
                end
                default:
                begin
                    if (b == sct_pkg::CHAR_AMP)
                        lex_mode = SCAN_AMP;
                    else if (b == sct_pkg::CHAR_BAR)
                        lex_mode = SCAN_BAR;
                    else
                        lex_mode = SCAN_WORD;
                    lex_tok_start = here;
                    lex_tok_len = 16'd1;
                end
            endcase
        end
        for (int i = 0; i < n; i++)
        begin
            made[i].last = (i == n - 1);
            tokens_due.push_back(made[i]);
        end
    endtask

    // Offers one byte request, possibly after an idle gap, and returns at the edge
    // where it is accepted. Valid stays high so back-to-back requests need no toggle.
    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 6) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_in <= b;
        do
            @(posedge clk);
        while (!byte_ready);
        lex_byte(b);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus a long hold-off when a test asks for one.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                token_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                token_ready <= 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                token_ready <= 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
                token_ready <= 1'b1;
        end
    end

    initial
    begin
        sct_pkg::token_t want;
        bit     bad;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_valid && token_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no token, actual kind=%0d start=%0d len=%0d line=%0d",
                             $time, token_kind, token_start, token_length, line_number);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    bad = (token_kind !== want.kind) || (token_start !== want.start) ||
                          (token_length !== want.length) || (line_number !== want.line) ||
                          (last_of_run !== want.last);
                    if (bad)
                    begin
                        mismatches++;
                        if (token_kind !== want.kind)
                            $display("%0t: token_kind expected %0d actual %0d",
                                     $time, want.kind, token_kind);
                        if (token_start !== want.start)
                            $display("%0t: token_start expected %0d actual %0d",
                                     $time, want.start, token_start);
                        if (token_length !== want.length)
                            $display("%0t: token_length expected %0d actual %0d",
                                     $time, want.length, token_length);
                        if (line_number !== want.line)
                            $display("%0t: line_number expected %0d actual %0d",
                                     $time, want.line, line_number);
                        if (last_of_run !== want.last)
                            $display("%0t: last_of_run expected %0d actual %0d",
                                     $time, want.last, last_of_run);
                    end
                end
            end
        end
    end

    // Every operator, whitespace, word characters, a digit and a high byte, and
    // pending tokens flushed by a following byte and by the end of the buffer.
    task automatic test_directed();
        send_text("a_./Z9");
        send_text("&&&||");
        send_text("|#<>");
        send_byte(sct_pkg::CHAR_TAB);
        send_byte(sct_pkg::CHAR_SPACE);
        send_byte(sct_pkg::CHAR_NL);
        send_byte(8'hFF);
        send_byte(sct_pkg::CHAR_NUL);
        send_byte(sct_pkg::CHAR_BAR);
        send_byte(sct_pkg::CHAR_NUL);
        send_byte(sct_pkg::CHAR_AMP);
        send_byte(8'h80);
        wait_drained();
    endtask

    // Mostly command-like text built from words and operators, with noise bytes mixed in.
    task automatic test_random_text();
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < 900)
        begin
            if (sent % 150 == 0)
                idling_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 5))
                        0:       send_byte(8'(8'h41 + $urandom_range(0, 25)));
                        1:       send_byte($urandom_range(0, 2) == 0 ? sct_pkg::CHAR_UNDER :
                                           ($urandom_range(0, 1) ? sct_pkg::CHAR_DOT :
                                                                   sct_pkg::CHAR_SLASH));
                        default: send_byte(8'(8'h61 + $urandom_range(0, 25)));
                    endcase
                end
                sent += len;
            end
            else if (pick < 55)
            begin
                send_byte($urandom_range(0, 3) == 0 ? sct_pkg::CHAR_TAB : sct_pkg::CHAR_SPACE);
                sent++;
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 3))
                    0:       send_text("&&");
                    1:       send_text("||");
                    2:       send_byte(sct_pkg::CHAR_AMP);
                    default: send_byte(sct_pkg::CHAR_BAR);
                endcase
                sent += 2;
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 2))
                    0:       send_byte(sct_pkg::CHAR_LT);
                    1:       send_byte(sct_pkg::CHAR_GT);
                    default: send_byte(sct_pkg::CHAR_HASH);
                endcase
                sent++;
            end
            else if (pick < 86)
            begin
                send_byte(sct_pkg::CHAR_NL);
                sent++;
            end
            else if (pick < 91)
            begin
                send_byte(8'(8'h30 + $urandom_range(0, 9)));
                sent++;
            end
            else if (pick < 97)
            begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                send_byte(sct_pkg::CHAR_NUL);
                sent++;
            end
        end
        idling_on = 1'b1;
        wait_drained();
    endtask

    // The receiver holds off while one- and two-token bytes keep coming, so the
    // output queue fills and the input must stall.
    task automatic test_backpressure();
        hold_off_cycles = 200;
        for (int i = 0; i < 12; i++)
            send_text("a|b&<");
        wait_drained();
    endtask

    // The sender stops until all tokens have come back, then carries on mid-buffer.
    // This closes the run, so both sides run without idling here.
    task automatic test_drain_pause();
        idling_on = 1'b0;
        send_text("ls -l|");
        wait_drained();
        send_text("|wc&");
        wait_drained();
        send_text(">out");
        send_byte(sct_pkg::CHAR_NUL);
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text();
        test_backpressure();
        test_drain_pause();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
